// ===== hdl/sirl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sirl_pkg;

    localparam int FIELD_W  = 32;
    localparam int CNT_W    = 11;
    localparam int IDX_W    = 10;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_MATCHES = 64;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_OFFSET_BITS = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== hdl/sirl_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sirl_table
    import sirl_pkg::*;
#(
    parameter int DEPTH  = DEF_TABLE_DEPTH,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire t_mem_ctl          i_ctl,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/sirl_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sirl_seq
    import sirl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_MATCHES = DEF_MAX_MATCHES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int OFF_W       = DEF_OFFSET_BITS,
    parameter int ADDR_W      = 10,
    parameter int DATA_W      = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CNT_W-1:0]   i_entry_count,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic               i_operation,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire logic [FIELD_W-1:0] i_key,
    input  wire logic [FIELD_W-1:0] i_entry_offset,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      logic               o_found,
    output      logic [FIELD_W-1:0] o_match_offset,
    output      logic               o_last,
    output      logic               o_truncated,
    output      t_mem_ctl           o_mem_ctl,
    output      logic [ADDR_W-1:0]  o_wr_addr,
    output      logic [DATA_W-1:0]  o_wr_data,
    output      logic [ADDR_W-1:0]  o_rd_addr,
    input  wire logic [DATA_W-1:0]  i_rd_data
);

    localparam int MCNT_W = $clog2(MAX_MATCHES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_FIRST,
        S_MISS,
        S_NEXT,
        S_CHK
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_n;
    logic [KEY_BITS-1:0] r_key;
    logic [OFF_W-1:0]    r_pend;
    logic [MCNT_W-1:0]   r_cnt;
    logic                r_ovalid;
    logic                r_found;
    logic [FIELD_W-1:0]  r_off;
    logic                r_last;
    logic                r_trunc;

    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    n_clamp;
    logic [KEY_BITS-1:0] rd_key;
    logic [OFF_W-1:0]    rd_off;
    logic                out_free;
    logic                in_acc;
    logic                key_match;
    logic                beat_load;

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign n_clamp   = (32'(i_entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : i_entry_count;
    assign rd_key    = i_rd_data[DATA_W-1:OFF_W];
    assign rd_off    = i_rd_data[OFF_W-1:0];
    assign key_match = (rd_key == r_key);
    assign out_free  = !r_ovalid || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign beat_load = out_free && ((r_state == S_MISS) || (r_state == S_CHK)
                       || ((r_state == S_NEXT) && !(r_lo < r_n)));

    // table port control
    always_comb begin
        o_mem_ctl.wr_en = in_acc && (i_operation == OP_WRITE)
                          && (32'(i_entry_index) < 32'(TABLE_DEPTH));
        o_mem_ctl.rd_en = 1'b0;
        o_rd_addr       = ADDR_W'(r_lo);
        case (r_state)
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_rd_addr       = ADDR_W'(mid);
                end else if (r_lo < r_n) begin
                    o_mem_ctl.rd_en = 1'b1;
                end
            end
            S_NEXT: begin
                o_mem_ctl.rd_en = (r_lo < r_n);
            end
            default: begin
                o_mem_ctl.rd_en = 1'b0;
            end
        endcase
    end

    assign o_wr_addr = ADDR_W'(i_entry_index);
    assign o_wr_data = {i_key[KEY_BITS-1:0], i_entry_offset[OFF_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (beat_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_operation == OP_LOOKUP)) begin
                        r_key   <= i_key[KEY_BITS-1:0];
                        r_n     <= n_clamp;
                        r_lo    <= '0;
                        r_hi    <= n_clamp;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_CMP;
                    end else if (r_lo < r_n) begin
                        r_state <= S_FIRST;
                    end else begin
                        r_state <= S_MISS;
                    end
                end
                S_CMP: begin
                    if (rd_key < r_key) begin
                        r_lo <= mid + CNT_W'(1);
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_PROBE;
                end
                S_FIRST: begin
                    if (!key_match) begin
                        r_state <= S_MISS;
                    end else begin
                        r_pend  <= rd_off;
                        r_cnt   <= MCNT_W'(1);
                        r_lo    <= r_lo + CNT_W'(1);
                        r_state <= S_NEXT;
                    end
                end
                S_MISS: begin
                    if (out_free) begin
                        r_found  <= 1'b0;
                        r_off    <= '0;
                        r_last   <= 1'b1;
                        r_trunc  <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_NEXT: begin
                    if (r_lo < r_n) begin
                        r_state <= S_CHK;
                    end else if (out_free) begin
                        r_found  <= 1'b1;
                        r_off    <= FIELD_W'(r_pend);
                        r_last   <= 1'b1;
                        r_trunc  <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_CHK: begin
                    if (out_free) begin
                        r_found  <= 1'b1;
                        r_off    <= FIELD_W'(r_pend);
                        if ((r_cnt == MCNT_W'(MAX_MATCHES)) || !key_match) begin
                            // more equal keys past the limit set the truncated flag
                            r_last  <= 1'b1;
                            r_trunc <= key_match;
                            r_state <= S_IDLE;
                        end else begin
                            r_last  <= 1'b0;
                            r_trunc <= 1'b0;
                            r_pend  <= rd_off;
                            r_cnt   <= r_cnt + MCNT_W'(1);
                            r_lo    <= r_lo + CNT_W'(1);
                            r_state <= S_NEXT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_found        = r_found;
    assign o_match_offset = r_off;
    assign o_last         = r_last;
    assign o_truncated    = r_trunc;

    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.rd_en && o_mem_ctl.wr_en))
        else $error("table read and write in the same cycle");

    a_lookup_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_LOOKUP)) |=> !o_ready)
        else $error("input taken while a lookup is in flight");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MCNT_W'(MAX_MATCHES))
        else $error("match count past limit");

    a_miss_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_found) |-> (r_last && !r_trunc && (r_off == '0)))
        else $error("miss beat malformed");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_trunc) |-> r_last)
        else $error("truncated beat not last");

endmodule

`default_nettype wire

// ===== hdl/sorted_index_equal_range_lookup_core.sv =====
// write beat: accepted when idle, in-range index written at the accepting edge, no result
// lookup beat: s = search steps (table read, compare) before the first result,
//   at most ceil(log2(n+1)) for entry count n; then one table read per further match
// one lookup in flight; dependent table reads set the pace, a stalled result holds the search
// output register holds the last result beat while the next beat is accepted
// reset clears entry_count and control state; table contents are kept, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module sorted_index_equal_range_lookup_core
    import sirl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_MATCHES = DEF_MAX_MATCHES,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CNT_W-1:0]   i_cfg_wdata,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic               i_operation,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire logic [FIELD_W-1:0] i_key,
    input  wire logic [FIELD_W-1:0] i_entry_offset,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      logic               o_found,
    output      logic [FIELD_W-1:0] o_match_offset,
    output      logic               o_last,
    output      logic               o_truncated
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OFF_W  = (OFFSET_BITS < FIELD_W) ? OFFSET_BITS : FIELD_W;
    localparam int DATA_W = KEY_BITS + OFF_W;

    logic [CNT_W-1:0]  r_entry_count;
    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    sirl_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sirl_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCHES (MAX_MATCHES),
        .KEY_BITS    (KEY_BITS),
        .OFF_W       (OFF_W),
        .ADDR_W      (ADDR_W),
        .DATA_W      (DATA_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_count  (r_entry_count),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_key          (i_key),
        .i_entry_offset (i_entry_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset),
        .o_last         (o_last),
        .o_truncated    (o_truncated),
        .o_mem_ctl      (mem_ctl),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data)
    );

endmodule

`default_nettype wire
